FILE: src/dmwc_pkg.sv
// Shared package of the direct-mapped write-back cache tag store.
// Holds default parameter values, fixed field widths and the command and
// status bundles between the controller and the datapath. No dependencies.
`timescale 1ns / 1ps

package dmwc_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned DefBlockBytes  = 64;
  localparam int unsigned DefSetCount    = 1024;
  localparam int unsigned DefAddressBits = 32;

  // Fixed widths of the address field and the running counts.
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned CNT_W  = 32;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear_step;  // write one cleared entry during the reset sweep
    logic capture;     // take an input word and read its set
    logic commit;      // update the set, the counts and the result register
  } dmwc_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_last;  // the sweep is at the last set
  } dmwc_sts_t;

endpackage : dmwc_pkg

FILE: src/dmwc_ctrl.sv
// Controller of the direct-mapped write-back cache tag store.
// Runs the reset clearing sweep, the accept and update sequence and the
// result valid flag. Depends on dmwc_pkg.
`timescale 1ns / 1ps

module dmwc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  dmwc_pkg::dmwc_sts_t sts_i,
  output dmwc_pkg::dmwc_cmd_t cmd_o
);
  import dmwc_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR  = 3'b001,
    S_IDLE   = 3'b010,
    S_UPDATE = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_taken;

  // The result register is free when empty or being taken this cycle.
  assign out_taken = out_valid_q && !out_stall_i;

  // Commands to the datapath.
  always_comb begin
    cmd_o            = '0;
    cmd_o.clear_step = (state_q == S_CLEAR);
    cmd_o.capture    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.commit     = (state_q == S_UPDATE) && (!out_valid_q || out_taken);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (cmd_o.commit) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // Result valid: set by a commit, cleared when the word is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_taken) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // An accepted word always moves on to the update step.
  a_accept_to_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_UPDATE))
    else $error("accepted word did not reach the update step");

  // A commit never overwrites a result that is still waiting.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");

  // A commit always presents a result in the next cycle.
  a_commit_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("commit did not raise result valid");

  // The sweep ends at the last set.
  a_sweep_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && sts_i.clear_last) |=> (state_q == S_IDLE))
    else $error("clearing sweep did not end at the last set");

endmodule : dmwc_ctrl

FILE: src/dmwc_dpath.sv
// Datapath of the direct-mapped write-back cache tag store.
// Holds the tag memory, the address split, the hit test, the saturating
// counts and the result register. Depends on dmwc_pkg.
`timescale 1ns / 1ps

module dmwc_dpath #(
  parameter int unsigned BLOCK_BYTES  = dmwc_pkg::DefBlockBytes,
  parameter int unsigned SET_COUNT    = dmwc_pkg::DefSetCount,
  parameter int unsigned ADDRESS_BITS = dmwc_pkg::DefAddressBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dmwc_pkg::dmwc_cmd_t           cmd_i,
  output dmwc_pkg::dmwc_sts_t           sts_o,
  input  logic [dmwc_pkg::ADDR_W-1:0]   address_i,
  input  logic                          is_write_i,
  output logic                          hit_o,
  output logic                          writeback_o,
  output logic [dmwc_pkg::ADDR_W-1:0]   writeback_address_o,
  output logic [dmwc_pkg::CNT_W-1:0]    hit_count_o,
  output logic [dmwc_pkg::CNT_W-1:0]    miss_count_o,
  output logic [dmwc_pkg::CNT_W-1:0]    flush_count_o
);
  import dmwc_pkg::*;

  // Address split. Bits above the address width are zero, so the tag keeps
  // at least one bit even when offset and index cover the whole address.
  localparam int unsigned OFF_W   = $clog2(BLOCK_BYTES);
  localparam int unsigned IDX_W   = $clog2(SET_COUNT);
  localparam int unsigned EFF_W   = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
  localparam int          TAG_RAW = int'(EFF_W) - int'(OFF_W) - int'(IDX_W);
  localparam int unsigned TAG_W   = (TAG_RAW < 1) ? 1 : TAG_RAW;
  localparam int unsigned FULL_W  = OFF_W + IDX_W + TAG_W;
  localparam int unsigned ENTRY_W = TAG_W + 2;
  localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((64'(1) << EFF_W) - 64'(1));

  // Memory entry: valid, dirty, tag.
  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [TAG_W-1:0] tag;
  } entry_t;

  logic [ENTRY_W-1:0]         mem_q [SET_COUNT];
  entry_t                     rd_q;
  logic [IDX_W-1:0]           idx_q;
  logic [TAG_W-1:0]           tag_q;
  logic                       wr_q;
  logic [IDX_W-1:0]           clr_idx_q;
  logic [FULL_W+ADDR_W-1:0]   addr_ext;
  logic [FULL_W-1:0]          addr_full;
  logic [IDX_W-1:0]           in_idx;
  logic [TAG_W-1:0]           in_tag;
  logic                       is_hit;
  logic                       is_victim;
  entry_t                     new_entry;
  logic                       mem_we;
  logic [IDX_W-1:0]           mem_wa;
  logic [ENTRY_W-1:0]         mem_wd;
  logic [FULL_W-1:0]          wb_full;
  logic [FULL_W+ADDR_W-1:0]   wb_ext;
  logic [CNT_W-1:0]           hits_q, misses_q, flushes_q;
  logic                       hit_q, wb_q;
  logic [ADDR_W-1:0]          wb_addr_q;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  // Split the incoming address into set index and tag.
  assign addr_ext  = {{FULL_W{1'b0}}, address_i & ADDR_MASK};
  assign addr_full = addr_ext[FULL_W-1:0];
  assign in_idx    = addr_full[OFF_W +: IDX_W];
  assign in_tag    = addr_full[OFF_W + IDX_W +: TAG_W];

  // Hit test on the registered set contents.
  assign is_hit    = rd_q.valid && (rd_q.tag == tag_q);
  assign is_victim = rd_q.valid && rd_q.dirty && !is_hit;

  // Entry written back on commit: a hit only gains dirt, a miss refills.
  always_comb begin
    new_entry.valid = 1'b1;
    new_entry.tag   = tag_q;
    new_entry.dirty = is_hit ? (rd_q.dirty || wr_q) : wr_q;
  end

  // Memory write port: clearing sweep or commit.
  assign mem_we = cmd_i.clear_step || cmd_i.commit;
  assign mem_wa = cmd_i.clear_step ? clr_idx_q : idx_q;
  assign mem_wd = cmd_i.clear_step ? '0 : ENTRY_W'(new_entry);

  // Tag memory with registered read on capture.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (cmd_i.capture) begin
      rd_q <= entry_t'(mem_q[in_idx]);
    end
  end

  // Request register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      idx_q <= in_idx;
      tag_q <= in_tag;
      wr_q  <= is_write_i;
    end
  end

  // Clearing sweep pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_idx_q <= clr_idx_q + IDX_W'(1);
    end
  end

  assign sts_o.clear_last = (clr_idx_q == IDX_W'(SET_COUNT - 1));

  // Block-aligned victim address, cut to the output width.
  assign wb_full = {rd_q.tag, idx_q, {OFF_W{1'b0}}};
  assign wb_ext  = {{ADDR_W{1'b0}}, wb_full};

  // Running counts, saturating.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q    <= '0;
      misses_q  <= '0;
      flushes_q <= '0;
    end else if (cmd_i.commit) begin
      if (is_hit) begin
        hits_q <= sat_inc(hits_q);
      end else begin
        misses_q <= sat_inc(misses_q);
      end
      if (is_victim) begin
        flushes_q <= sat_inc(flushes_q);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_q     <= is_hit;
      wb_q      <= is_victim;
      wb_addr_q <= is_victim ? wb_ext[ADDR_W-1:0] : '0;
    end
  end

  // The counts change only on a commit, which waits for the result register.
  assign hit_o               = hit_q;
  assign writeback_o         = wb_q;
  assign writeback_address_o = wb_addr_q;
  assign hit_count_o         = hits_q;
  assign miss_count_o        = misses_q;
  assign flush_count_o       = flushes_q;

endmodule : dmwc_dpath

FILE: src/direct_mapped_writeback_cache_tags.sv
// Channel  | Valid       | Stall        | Word
// ---------+-------------+--------------+------------------------------------------------
// input    | in_valid_i  | in_stall_o   | address_i, is_write_i
// output   | out_valid_o | out_stall_i  | hit_o, writeback_o, writeback_address_o,
//          |             |              | hit_count_o, miss_count_o, flush_count_o
//
// In an access, the accept step reads its set from the tag memory, and the update step
// then compares, writes the set back and loads the result.
// Each access is a read-modify-write of the tag memory; no new word is taken until it is done.
// After reset the block clears every set, one per cycle, before the first word is accepted.
// The update waits while a previous result is still stalled at the output.
//
// Top level of the direct-mapped write-back cache tag store.
// Depends on dmwc_pkg, dmwc_ctrl and dmwc_dpath.
`timescale 1ns / 1ps

module direct_mapped_writeback_cache_tags #(
  parameter int unsigned BLOCK_BYTES  = dmwc_pkg::DefBlockBytes,
  parameter int unsigned SET_COUNT    = dmwc_pkg::DefSetCount,
  parameter int unsigned ADDRESS_BITS = dmwc_pkg::DefAddressBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [dmwc_pkg::ADDR_W-1:0] address_i,
  input  logic                        is_write_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        hit_o,
  output logic                        writeback_o,
  output logic [dmwc_pkg::ADDR_W-1:0] writeback_address_o,
  output logic [dmwc_pkg::CNT_W-1:0]  hit_count_o,
  output logic [dmwc_pkg::CNT_W-1:0]  miss_count_o,
  output logic [dmwc_pkg::CNT_W-1:0]  flush_count_o
);
  import dmwc_pkg::*;

  dmwc_cmd_t cmd;
  dmwc_sts_t sts;

  // Sequencing of clear, accept and update.
  dmwc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Tag memory, hit test and counts.
  dmwc_dpath #(
    .BLOCK_BYTES  (BLOCK_BYTES),
    .SET_COUNT    (SET_COUNT),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .address_i           (address_i),
    .is_write_i          (is_write_i),
    .hit_o               (hit_o),
    .writeback_o         (writeback_o),
    .writeback_address_o (writeback_address_o),
    .hit_count_o         (hit_count_o),
    .miss_count_o        (miss_count_o),
    .flush_count_o       (flush_count_o)
  );

endmodule : direct_mapped_writeback_cache_tags

FILE: bench/dmwc_access_monitor.sv
// Monitor for the direct-mapped write-back cache tag store: predicts each lookup result
// from the accepted access words and compares it with the words leaving the block.
// Depends on dmwc_pkg for the address and count widths and the default geometry.
`timescale 1ns / 1ps

module dmwc_access_monitor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [dmwc_pkg::ADDR_W-1:0] address_i,
  input  logic                        is_write_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic                        hit_i,
  input  logic                        writeback_i,
  input  logic [dmwc_pkg::ADDR_W-1:0] writeback_address_i,
  input  logic [dmwc_pkg::CNT_W-1:0]  hit_count_i,
  input  logic [dmwc_pkg::CNT_W-1:0]  miss_count_i,
  input  logic [dmwc_pkg::CNT_W-1:0]  flush_count_i,
  output int                          mismatches_o,
  output int                          pending_o
);

  localparam int OFFSET_W = $clog2(dmwc_pkg::DefBlockBytes);
  localparam int INDEX_W  = $clog2(dmwc_pkg::DefSetCount);
  localparam int TAG_W    = dmwc_pkg::DefAddressBits - OFFSET_W - INDEX_W;
  localparam int SETS     = dmwc_pkg::DefSetCount;
  localparam int MAX_SHOWN = 40;

  typedef struct packed {
    logic                        hit;
    logic                        writeback;
    logic [dmwc_pkg::ADDR_W-1:0] victim_addr;
    logic [dmwc_pkg::CNT_W-1:0]  hits;
    logic [dmwc_pkg::CNT_W-1:0]  misses;
    logic [dmwc_pkg::CNT_W-1:0]  flushes;
  } lookup_result_t;

  // Shadow copy of the tag store and the running counts.
  logic                       shadow_valid [SETS];
  logic                       shadow_dirty [SETS];
  logic [TAG_W-1:0]           shadow_tag   [SETS];
  logic [dmwc_pkg::CNT_W-1:0] hits_seen;
  logic [dmwc_pkg::CNT_W-1:0] misses_seen;
  logic [dmwc_pkg::CNT_W-1:0] flushes_seen;

  lookup_result_t expected_lookups [$];
  int             mismatches;

  // Counts stick at all ones once they get there.
  function automatic logic [dmwc_pkg::CNT_W-1:0] sat_bump(input logic [dmwc_pkg::CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // Looks one access up in the shadow store, updates it and returns the result word.
  function automatic lookup_result_t resolve_access(input logic [dmwc_pkg::ADDR_W-1:0] addr,
                                                    input logic                        wr);
    logic [INDEX_W-1:0] set_idx;
    logic [TAG_W-1:0]   addr_tag;
    lookup_result_t     res;
    set_idx  = addr[OFFSET_W +: INDEX_W];
    addr_tag = addr[dmwc_pkg::DefAddressBits-1 -: TAG_W];
    res      = '0;
    if (shadow_valid[set_idx] && shadow_tag[set_idx] == addr_tag) begin
      res.hit   = 1'b1;
      hits_seen = sat_bump(hits_seen);
      if (wr) begin
        shadow_dirty[set_idx] = 1'b1;
      end
    end else begin
      misses_seen = sat_bump(misses_seen);
      // A valid dirty victim leaves at its block-aligned address.
      if (shadow_valid[set_idx] && shadow_dirty[set_idx]) begin
        res.writeback   = 1'b1;
        res.victim_addr = {shadow_tag[set_idx], set_idx, {OFFSET_W{1'b0}}};
        flushes_seen    = sat_bump(flushes_seen);
      end
      shadow_valid[set_idx] = 1'b1;
      shadow_tag[set_idx]   = addr_tag;
      shadow_dirty[set_idx] = wr;
    end
    res.hits    = hits_seen;
    res.misses  = misses_seen;
    res.flushes = flushes_seen;
    return res;
  endfunction

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(input string what);
    if (mismatches < MAX_SHOWN) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    mismatches = mismatches + 1;
  endtask

  // Checks the result word first, then records the access word of the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t want;
    if (!rst_ni) begin
      for (int s = 0; s < SETS; s++) begin
        shadow_valid[s] = 1'b0;
        shadow_dirty[s] = 1'b0;
        shadow_tag[s]   = '0;
      end
      hits_seen    = '0;
      misses_seen  = '0;
      flushes_seen = '0;
      expected_lookups.delete();
      mismatches   = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_lookups.size() == 0) begin
          report_mismatch("result word with no access outstanding");
        end else begin
          want = expected_lookups.pop_front();
          if (hit_i !== want.hit)
            report_mismatch($sformatf("hit got %b want %b", hit_i, want.hit));
          if (writeback_i !== want.writeback)
            report_mismatch($sformatf("writeback got %b want %b", writeback_i, want.writeback));
          if (writeback_address_i !== want.victim_addr)
            report_mismatch($sformatf("writeback_address got %h want %h",
                                      writeback_address_i, want.victim_addr));
          if (hit_count_i !== want.hits)
            report_mismatch($sformatf("hit_count got %0d want %0d", hit_count_i, want.hits));
          if (miss_count_i !== want.misses)
            report_mismatch($sformatf("miss_count got %0d want %0d", miss_count_i, want.misses));
          if (flush_count_i !== want.flushes)
            report_mismatch($sformatf("flush_count got %0d want %0d",
                                      flush_count_i, want.flushes));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_lookups.push_back(resolve_access(address_i, is_write_i));
      end
    end
    mismatches_o = mismatches;
    pending_o    = expected_lookups.size();
  end

endmodule

FILE: bench/tb.sv
// Testbench top for the direct-mapped write-back cache tag store: clock, reset, access
// stimulus with bursty valid and random output stall, watchdog and the final verdict.
// Depends on dmwc_pkg, direct_mapped_writeback_cache_tags and dmwc_access_monitor.
`timescale 1ns / 1ps

module tb;

  localparam int OFFSET_W     = $clog2(dmwc_pkg::DefBlockBytes);
  localparam int INDEX_W      = $clog2(dmwc_pkg::DefSetCount);
  localparam int TAG_W        = dmwc_pkg::DefAddressBits - OFFSET_W - INDEX_W;
  localparam int RANDOM_WORDS = 1100;
  localparam int IDLE_LIMIT   = 8000;
  localparam int TAIL_CYCLES  = 8;
  localparam logic ACC_READ   = 1'b0;
  localparam logic ACC_WRITE  = 1'b1;

  logic                        clk        = 1'b0;
  logic                        rst_n      = 1'b0;
  logic                        in_valid   = 1'b0;
  logic                        in_stall;
  logic [dmwc_pkg::ADDR_W-1:0] address    = '0;
  logic                        is_write   = 1'b0;
  logic                        out_valid;
  logic                        out_stall  = 1'b0;
  logic                        hit;
  logic                        writeback;
  logic [dmwc_pkg::ADDR_W-1:0] writeback_address;
  logic [dmwc_pkg::CNT_W-1:0]  hit_count;
  logic [dmwc_pkg::CNT_W-1:0]  miss_count;
  logic [dmwc_pkg::CNT_W-1:0]  flush_count;
  int                          mismatches;
  int                          pending;
  int                          burst_left = 0;
  int                          idle_cycles = 0;
  logic [INDEX_W-1:0]          hot_sets [8];
  logic [TAG_W-1:0]            hot_tags [4];

  direct_mapped_writeback_cache_tags #(
    .BLOCK_BYTES (dmwc_pkg::DefBlockBytes),
    .SET_COUNT   (dmwc_pkg::DefSetCount),
    .ADDRESS_BITS(dmwc_pkg::DefAddressBits)
  ) i_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .address_i          (address),
    .is_write_i         (is_write),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .hit_o              (hit),
    .writeback_o        (writeback),
    .writeback_address_o(writeback_address),
    .hit_count_o        (hit_count),
    .miss_count_o       (miss_count),
    .flush_count_o      (flush_count)
  );

  dmwc_access_monitor i_monitor (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .address_i          (address),
    .is_write_i         (is_write),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .hit_i              (hit),
    .writeback_i        (writeback),
    .writeback_address_i(writeback_address),
    .hit_count_i        (hit_count),
    .miss_count_i       (miss_count),
    .flush_count_i      (flush_count),
    .mismatches_o       (mismatches),
    .pending_o          (pending)
  );

  // Free-running clock.
  initial begin
    forever #1 clk = ~clk;
  end

  // Sends one access word, opening a new burst with a random gap when the last one ran out.
  task automatic issue_access(input logic [dmwc_pkg::ADDR_W-1:0] addr, input logic wr);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left = burst_left - 1;
    @(negedge clk);
    in_valid = 1'b1;
    address  = addr;
    is_write = wr;
    do @(posedge clk); while (in_stall);
  endtask

  // Output stall follows its own pattern: free runs, coin flips, light stall and short full-stall holds.
  initial begin
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = (mode == 3) ? $urandom_range(1, 12) : $urandom_range(5, 40);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = $urandom_range(0, 1);
          2: out_stall = ($urandom_range(0, 3) == 0);
          default: out_stall = 1'b1;
        endcase
      end
    end
  end

  // Watchdog: ends the run when no word moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("** direct_mapped_writeback_cache_tags: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int pick;
    logic [dmwc_pkg::ADDR_W-1:0] addr;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed: cold misses, hits at both offset extremes, dirty victims at the
    // address extremes, a victim whose address is zero, and clean evictions.
    issue_access(32'h0000_0000, ACC_READ);
    issue_access(32'h0000_003F, ACC_WRITE);
    issue_access(32'h0001_0000, ACC_READ);
    issue_access(32'h0001_0004, ACC_READ);
    issue_access(32'h0002_0000, ACC_READ);
    issue_access(32'hFFFF_FFFF, ACC_WRITE);
    issue_access(32'hFFFF_FFC0, ACC_READ);
    issue_access(32'h0000_FFC0, ACC_WRITE);
    issue_access(32'hFFFF_FFC0, ACC_WRITE);
    issue_access(32'hFFFF_FFE0, ACC_READ);
    issue_access(32'h8000_0000, ACC_READ);
    issue_access(32'h8000_0000, ACC_WRITE);
    issue_access(32'h0000_0000, ACC_WRITE);
    issue_access(32'h5555_5555, ACC_WRITE);
    issue_access(32'hAAAA_AAAA, ACC_WRITE);
    issue_access(32'hAAAA_AAAA, ACC_READ);
    issue_access(32'h5555_5540, ACC_READ);
    issue_access(32'h0000_0040, ACC_WRITE);
    issue_access(32'h0001_0040, ACC_WRITE);
    issue_access(32'h0001_0040, ACC_READ);
    issue_access(32'h0000_0040, ACC_READ);

    // A few hot sets and tags make hits, dirty evictions and back-to-back
    // accesses to one set common; the rest are conflicts and full-range noise.
    hot_sets[0] = '0;
    hot_sets[1] = '1;
    for (int i = 2; i < 8; i++) hot_sets[i] = INDEX_W'($urandom);
    hot_tags[0] = '0;
    hot_tags[1] = '1;
    for (int i = 2; i < 4; i++) hot_tags[i] = TAG_W'($urandom);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        addr = {hot_tags[$urandom_range(0, 3)], hot_sets[$urandom_range(0, 7)],
                OFFSET_W'($urandom)};
      end else if (pick < 9) begin
        addr = {TAG_W'($urandom), hot_sets[$urandom_range(0, 7)], OFFSET_W'($urandom)};
      end else begin
        addr = $urandom;
      end
      issue_access(addr, $urandom_range(0, 1) ? ACC_WRITE : ACC_READ);
    end

    @(negedge clk);
    in_valid = 1'b0;

    // Drain the outstanding results, then let the pipeline settle.
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("** direct_mapped_writeback_cache_tags: PASSED **");
    end else begin
      $display("** direct_mapped_writeback_cache_tags: FAILED **");
    end
    $finish;
  end

endmodule

FILE: direct_mapped_writeback_cache_tags.f
src/dmwc_pkg.sv
src/dmwc_ctrl.sv
src/dmwc_dpath.sv
src/direct_mapped_writeback_cache_tags.sv
bench/dmwc_access_monitor.sv
bench/tb.sv
